/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg
// Types and constants shared by the motor drive supervisor modules.
// ----------------------------------------------------------------------------
package mds_pkg;

    localparam int ADC_W   = 12;
    localparam int OFF_W   = 12;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX         = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] TRIP_RESET_TICKS = 16'd20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREOPEN_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_NOM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TOL    = 3'd4;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] INIT_TICKS_RST    = 16'd100;
    localparam logic [TICK_W-1:0] STOP_TICKS_RST    = 16'd200;
    localparam logic [TICK_W-1:0] PREOPEN_TICKS_RST = 16'd1000;
    localparam logic [OFF_W-1:0]  OFFSET_NOM_RST    = 12'd2048;
    localparam logic [OFF_W-1:0]  OFFSET_TOL_RST    = 12'd100;

    // Supervisor states, as they appear on machine_state.
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_STOP    = 3'd1;
    localparam logic [2:0] MODE_PREOPEN = 3'd2;
    localparam logic [2:0] MODE_RUN     = 3'd3;
    localparam logic [2:0] MODE_ALARM   = 3'd4;

    typedef struct packed {
        logic [TICK_W-1:0] init_ticks;
        logic [TICK_W-1:0] stop_ticks;
        logic [TICK_W-1:0] preopen_ticks;
        logic [OFF_W-1:0]  offset_nominal;
        logic [OFF_W-1:0]  offset_tolerance;
    } cfg_t;

    typedef struct packed {
        logic             start_request;
        logic             external_fault;
        logic             fault_clear;
        logic [ADC_W-1:0] adc_u;
        logic [ADC_W-1:0] adc_v;
        logic [ADC_W-1:0] adc_w;
    } in_word_t;

    // Calibration status handed to the sequencer for the current tick.
    typedef struct packed {
        logic             done;
        logic             miss;
        logic [OFF_W-1:0] offset_u;
        logic [OFF_W-1:0] offset_v;
        logic [OFF_W-1:0] offset_w;
    } cal_status_t;

    typedef struct packed {
        logic [2:0]       machine_state;
        logic             pwm_enable;
        logic             preopen_active;
        logic             run_indicator;
        logic             estimator_reset;
        logic             trip_reset;
        logic [OFF_W-1:0] offset_u;
        logic [OFF_W-1:0] offset_v;
        logic [OFF_W-1:0] offset_w;
        logic             cal_fault;
        logic             clear_start;
    } result_t;

endpackage

/* src/mds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mds_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module mds_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mds_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mds_pkg::cfg_t                       cfg
);

    mds_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_ticks       <= mds_pkg::INIT_TICKS_RST;
            cfg_reg.stop_ticks       <= mds_pkg::STOP_TICKS_RST;
            cfg_reg.preopen_ticks    <= mds_pkg::PREOPEN_TICKS_RST;
            cfg_reg.offset_nominal   <= mds_pkg::OFFSET_NOM_RST;
            cfg_reg.offset_tolerance <= mds_pkg::OFFSET_TOL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mds_pkg::CFG_INIT_TICKS:    cfg_reg.init_ticks    <= cfg_data;
                mds_pkg::CFG_STOP_TICKS:    cfg_reg.stop_ticks    <= cfg_data;
                mds_pkg::CFG_PREOPEN_TICKS: cfg_reg.preopen_ticks <= cfg_data;
                mds_pkg::CFG_OFFSET_NOM:
                    cfg_reg.offset_nominal <= cfg_data[mds_pkg::OFF_W-1:0];
                mds_pkg::CFG_OFFSET_TOL:
                    cfg_reg.offset_tolerance <= cfg_data[mds_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/mds_cal_unit.sv */
// ----------------------------------------------------------------------------
// mds_cal_unit
// ADC offset calibration: per-phase accumulators, averaging and window check.
// ----------------------------------------------------------------------------
module mds_cal_unit
#(
    parameter int CAL_SAMPLES = 100,
    parameter int ADC_BITS    = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cal_en,
    input  mds_pkg::in_word_t     in_word,
    input  mds_pkg::cfg_t         cfg,
    output mds_pkg::cal_status_t  status
);

    localparam int AW = mds_pkg::ADC_W;
    localparam int OW = mds_pkg::OFF_W;
    localparam int SAMPLE_BITS = (ADC_BITS < AW) ? ADC_BITS : AW;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(CAL_SAMPLES + 1);
    localparam int CC_W    = $clog2(CAL_SAMPLES + 3);
    // Division by CAL_SAMPLES as a multiply by a rounded-up reciprocal. The
    // shift is wide enough that the quotient is exact for every sum.
    localparam int SHIFT   = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint RECIP_L =
        ((64'd1 << SHIFT) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [AW-1:0]   AMASK   = AW'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [CC_W-1:0] CC_LAST = CC_W'(CAL_SAMPLES);
    localparam logic [CC_W-1:0] CC_FIN  = CC_W'(CAL_SAMPLES + 1);

    logic [CC_W-1:0]  cc_reg;
    logic [CC_W-1:0]  cc_next;
    logic [CC_W-1:0]  cc_inc;
    logic [SUM_W-1:0] sum_reg  [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [OW-1:0]    off_reg  [3];
    logic [OW-1:0]    off_next [3];
    logic [AW-1:0]    sample   [3];
    logic [PROD_W-1:0] prod    [3];
    logic [OW-1:0]    quot     [3];
    logic [2:0]       lane_miss;
    logic             acc_phase;
    logic             fin_phase;

    assign sample[0] = in_word.adc_u & AMASK;
    assign sample[1] = in_word.adc_v & AMASK;
    assign sample[2] = in_word.adc_w & AMASK;

    assign cc_inc    = cc_reg + 1'b1;
    assign acc_phase = (cc_inc <= CC_LAST);
    assign fin_phase = (cc_inc == CC_FIN);

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic signed [OW+1:0] diff;
        logic signed [OW+1:0] tol_s;

        assign prod[i] = PROD_W'(sum_reg[i]) * PROD_W'(RECIP);
        assign quot[i] = OW'(prod[i] >> SHIFT);
        assign diff    = $signed({2'b00, quot[i]}) - $signed({2'b00, cfg.offset_nominal});
        assign tol_s   = $signed({2'b00, cfg.offset_tolerance});
        assign lane_miss[i] = (diff > tol_s) || (diff < -tol_s);
    end

    always_comb
    begin
        cc_next = cc_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = sum_reg[i];
            off_next[i] = off_reg[i];
        end
        if (cal_en)
        begin
            if (acc_phase)
            begin
                cc_next = cc_inc;
                for (int i = 0; i < 3; i++)
                begin
                    sum_next[i] = sum_reg[i] + SUM_W'(sample[i]);
                end
            end
            else if (fin_phase)
            begin
                cc_next = cc_inc;
                for (int i = 0; i < 3; i++)
                begin
                    off_next[i] = quot[i];
                end
            end
            else
            begin
                cc_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    sum_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end
        else
        begin
            cc_reg <= cc_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
                off_reg[i] <= off_next[i];
            end
        end
    end

    assign status.done     = !acc_phase && !fin_phase;
    assign status.miss     = fin_phase && (|lane_miss);
    assign status.offset_u = off_next[0];
    assign status.offset_v = off_next[1];
    assign status.offset_w = off_next[2];

endmodule

/* src/mds_seq.sv */
// ----------------------------------------------------------------------------
// mds_seq
// Supervisor state machine with tick timer, fault latch and result register.
// ----------------------------------------------------------------------------
module mds_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  out_ready,
    input  mds_pkg::in_word_t     in_word,
    input  mds_pkg::cfg_t         cfg,
    input  mds_pkg::cal_status_t  cal,
    output logic                  cal_en,
    output logic                  out_valid,
    output mds_pkg::result_t      result
);

    typedef enum logic [2:0] {
        ST_INIT    = mds_pkg::MODE_INIT,
        ST_STOP    = mds_pkg::MODE_STOP,
        ST_PREOPEN = mds_pkg::MODE_PREOPEN,
        ST_RUN     = mds_pkg::MODE_RUN,
        ST_ALARM   = mds_pkg::MODE_ALARM
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    state_t                         state_eff;
    logic [mds_pkg::TICK_W-1:0]     tick_reg;
    logic [mds_pkg::TICK_W-1:0]     tick_next;
    logic [mds_pkg::TICK_W-1:0]     tick_eff;
    logic [mds_pkg::TICK_W-1:0]     tick_inc;
    logic                           latch_reg;
    logic                           latch_next;
    logic                           latch_clr;
    logic                           run_reg;
    logic                           run_next;
    logic                           fault;
    logic                           to_alarm;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    mds_pkg::result_t               result_reg;
    mds_pkg::result_t               result_next;

    assign latch_clr = in_word.fault_clear ? 1'b0 : latch_reg;
    assign fault     = in_word.external_fault || latch_clr;
    assign to_alarm  = (state_reg != ST_INIT) && fault;
    assign state_eff = to_alarm ? ST_ALARM : state_reg;
    assign tick_eff  = to_alarm ? '0 : tick_reg;
    assign tick_inc  = (tick_eff == mds_pkg::TICK_MAX) ? tick_eff : tick_eff + 1'b1;
    assign cal_en    = step && (state_reg == ST_INIT);

    always_comb
    begin
        state_next  = state_eff;
        tick_next   = tick_eff;
        latch_next  = latch_clr;
        run_next    = run_reg;
        result_next = '0;

        case (state_eff)
            ST_INIT:
            begin
                run_next = 1'b0;
                tick_next = tick_inc;
                result_next.trip_reset = (tick_inc <= mds_pkg::TRIP_RESET_TICKS);
                if (cal.miss)
                begin
                    latch_next = 1'b1;
                end
                if (cal.done && (tick_inc >= cfg.init_ticks))
                begin
                    state_next = ST_STOP;
                    tick_next  = '0;
                end
            end
            ST_STOP:
            begin
                run_next  = 1'b0;
                tick_next = tick_inc;
                if (in_word.start_request && (tick_inc >= cfg.stop_ticks))
                begin
                    state_next = ST_PREOPEN;
                    tick_next  = '0;
                end
            end
            ST_PREOPEN:
            begin
                tick_next = tick_inc;
                result_next.pwm_enable      = 1'b1;
                result_next.preopen_active  = (tick_inc < cfg.preopen_ticks);
                result_next.estimator_reset = !(tick_inc < cfg.preopen_ticks);
                if (tick_inc > cfg.preopen_ticks)
                begin
                    state_next = ST_RUN;
                    tick_next  = '0;
                    run_next   = 1'b1;
                end
                // A dropped start request wins over entering run.
                if (!in_word.start_request)
                begin
                    state_next = ST_STOP;
                    tick_next  = '0;
                    run_next   = 1'b0;
                end
            end
            ST_RUN:
            begin
                result_next.pwm_enable = 1'b1;
                if (!in_word.start_request)
                begin
                    state_next = ST_STOP;
                    tick_next  = '0;
                    run_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_ALARM;
                run_next   = 1'b0;
                result_next.clear_start = 1'b1;
                if (!fault)
                begin
                    state_next = ST_INIT;
                    tick_next  = '0;
                    latch_next = 1'b0;
                end
            end
        endcase

        result_next.machine_state = state_next;
        result_next.run_indicator = run_next;
        result_next.cal_fault     = latch_next;
        result_next.offset_u      = cal.offset_u;
        result_next.offset_v      = cal.offset_v;
        result_next.offset_w      = cal.offset_w;
    end

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            tick_reg      <= '0;
            latch_reg     <= 1'b0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                state_reg  <= state_next;
                tick_reg   <= tick_next;
                latch_reg  <= latch_next;
                run_reg    <= run_next;
                result_reg <= result_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

/* src/motor_drive_supervisor_core.sv */
// ----------------------------------------------------------------------------
// motor_drive_supervisor_core
// Supervisory state machine of a motor drive with ADC offset calibration.
// ----------------------------------------------------------------------------
// Usage: each input word is one control tick carrying the start request, the
// external fault level, a fault clear and three phase-current ADC samples.
// Every accepted word produces exactly one result word on the output channel.
// Both channels use valid/ready; a word moves when valid and ready are both
// high at a rising clock edge.
// Datapath: an accepted word is captured in the input register; the result is
// computed from that register and registered in the result register, and
// out_valid is registered together with it.
// Throughput: one word per cycle unless out_ready stalls. The work for a tick
// is a short compare-and-add path plus one multiply by a reciprocal for the averaging.
// Stall: when out_ready is low the result word holds; the input register
// still takes one more word, and in_ready then drops until the result leaves.
// Reset: rst_n clears the state machine to init, the tick timer, calibration counters,
// offsets and fault latch, and loads the register defaults. Configuration writes take
// effect at the next edge; the user must make them while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module motor_drive_supervisor_core
#(
    parameter int CAL_SAMPLES = 100,
    parameter int ADC_BITS    = 12
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_write,
    input  logic [mds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mds_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_request,
    input  logic                              external_fault,
    input  logic                              fault_clear,
    input  logic [mds_pkg::ADC_W-1:0]         adc_u,
    input  logic [mds_pkg::ADC_W-1:0]         adc_v,
    input  logic [mds_pkg::ADC_W-1:0]         adc_w,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        machine_state,
    output logic                              pwm_enable,
    output logic                              preopen_active,
    output logic                              run_indicator,
    output logic                              estimator_reset,
    output logic                              trip_reset,
    output logic [mds_pkg::OFF_W-1:0]         offset_u,
    output logic [mds_pkg::OFF_W-1:0]         offset_v,
    output logic [mds_pkg::OFF_W-1:0]         offset_w,
    output logic                              cal_fault,
    output logic                              clear_start
);

    mds_pkg::cfg_t        cfg;
    mds_pkg::in_word_t    in_word_reg;
    mds_pkg::cal_status_t cal;
    mds_pkg::result_t     result;
    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic                 step;
    logic                 cal_en;

    // A tick is processed when the input register holds a word and the
    // result register is empty or being emptied in this cycle.
    assign step     = in_vld_reg && (!out_valid || out_ready);
    assign in_ready = !in_vld_reg || step;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg.start_request  <= start_request;
            in_word_reg.external_fault <= external_fault;
            in_word_reg.fault_clear    <= fault_clear;
            in_word_reg.adc_u          <= adc_u;
            in_word_reg.adc_v          <= adc_v;
            in_word_reg.adc_w          <= adc_w;
        end
    end

    mds_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Calibration only advances on ticks that are handled in init.
    mds_cal_unit
    #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .ADC_BITS    (ADC_BITS)
    )
    u_cal_unit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cal_en  (cal_en),
        .in_word (in_word_reg),
        .cfg     (cfg),
        .status  (cal)
    );

    mds_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .out_ready (out_ready),
        .in_word   (in_word_reg),
        .cfg       (cfg),
        .cal       (cal),
        .cal_en    (cal_en),
        .out_valid (out_valid),
        .result    (result)
    );

    assign machine_state   = result.machine_state;
    assign pwm_enable      = result.pwm_enable;
    assign preopen_active  = result.preopen_active;
    assign run_indicator   = result.run_indicator;
    assign estimator_reset = result.estimator_reset;
    assign trip_reset      = result.trip_reset;
    assign offset_u        = result.offset_u;
    assign offset_v        = result.offset_v;
    assign offset_w        = result.offset_w;
    assign cal_fault       = result.cal_fault;
    assign clear_start     = result.clear_start;

endmodule

/* src/mds_checker.sv */
// ----------------------------------------------------------------------------
// mds_checker
// Port-level checks of the motor drive supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mds_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [2:0]                 machine_state,
    input logic                       pwm_enable,
    input logic                       preopen_active,
    input logic                       run_indicator,
    input logic                       estimator_reset,
    input logic                       clear_start
);

    // A stalled result word holds its state field.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(machine_state), "result word changed while stalled")

    // The run indicator is only up while the machine sits in run.
    `ASSERT_IMPLIES(a_run_ind, clk, rst_n, out_valid && run_indicator, machine_state == mds_pkg::MODE_RUN, "run indicator outside run")

    // PWM is only enabled on ticks handled in preopen or run, which end in preopen, run or stop.
    `ASSERT_IMPLIES(a_pwm_state, clk, rst_n, out_valid && pwm_enable, machine_state == mds_pkg::MODE_PREOPEN || machine_state == mds_pkg::MODE_RUN || machine_state == mds_pkg::MODE_STOP, "pwm enabled in wrong state")

    // Preopen timing and estimator reset are mutually exclusive and need PWM.
    `ASSERT_IMPLIES(a_preopen, clk, rst_n, out_valid && preopen_active, pwm_enable && !estimator_reset, "preopen flags inconsistent")

    // The start-clear request only comes from alarm or its exit into init.
    `ASSERT_IMPLIES(a_clear_start, clk, rst_n, out_valid && clear_start, machine_state == mds_pkg::MODE_ALARM || machine_state == mds_pkg::MODE_INIT, "clear_start outside alarm")

endmodule

bind motor_drive_supervisor_core mds_checker u_mds_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .machine_state   (machine_state),
    .pwm_enable      (pwm_enable),
    .preopen_active  (preopen_active),
    .run_indicator   (run_indicator),
    .estimator_reset (estimator_reset),
    .clear_start     (clear_start)
);

/* tb/motor_drive_supervisor_core_test.sv */
// ----------------------------------------------------------------------------
// motor_drive_supervisor_core_test
// Self-checking bench for the motor drive supervisor. A driver offers control
// ticks from a queue of planned words in random bursts, a monitor stalls the
// result channel on its own pattern, and every result word is compared field
// by field with a cycle-free model of the supervisor kept in this module.
// ----------------------------------------------------------------------------
module motor_drive_supervisor_core_test;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    // Samples averaged per calibration pass; matches the core's default.
    localparam int CAL_WINDOW = 100;
    // Length of the long receiver hold used to back the core up.
    localparam int HOLD_CYCLES = 150;
    // Cycles without any handshake before the run is declared hung. The worst
    // legal stall is the long hold plus a sender gap and the pass through the
    // input and result registers, so this leaves a wide margin.
    localparam int HANG_LIMIT = 2000;
    // Extra wait at the end for results still passing the input and result registers.
    localparam int TAIL_CYCLES = 8;
    // Keep the log readable if the core is badly broken.
    localparam int REPORT_CAP = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_write = 1'b0;
    logic [mds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      start_request = 1'b0;
    logic                      external_fault = 1'b0;
    logic                      fault_clear = 1'b0;
    logic [mds_pkg::ADC_W-1:0] adc_u = '0;
    logic [mds_pkg::ADC_W-1:0] adc_v = '0;
    logic [mds_pkg::ADC_W-1:0] adc_w = '0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [2:0]                machine_state;
    logic                      pwm_enable;
    logic                      preopen_active;
    logic                      run_indicator;
    logic                      estimator_reset;
    logic                      trip_reset;
    logic [mds_pkg::OFF_W-1:0] offset_u;
    logic [mds_pkg::OFF_W-1:0] offset_v;
    logic [mds_pkg::OFF_W-1:0] offset_w;
    logic                      cal_fault;
    logic                      clear_start;

    motor_drive_supervisor_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .start_request   (start_request),
        .external_fault  (external_fault),
        .fault_clear     (fault_clear),
        .adc_u           (adc_u),
        .adc_v           (adc_v),
        .adc_w           (adc_w),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .machine_state   (machine_state),
        .pwm_enable      (pwm_enable),
        .preopen_active  (preopen_active),
        .run_indicator   (run_indicator),
        .estimator_reset (estimator_reset),
        .trip_reset      (trip_reset),
        .offset_u        (offset_u),
        .offset_v        (offset_v),
        .offset_w        (offset_w),
        .cal_fault       (cal_fault),
        .clear_start     (clear_start)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Supervisor model. It holds its own copy of the registers and of every
    // piece of state the core keeps, and advances by one control tick for
    // each word the core accepts.
    // ------------------------------------------------------------------------
    mds_pkg::cfg_t              settings;
    logic [2:0]                 sup_mode;
    logic [mds_pkg::TICK_W-1:0] sup_tick;
    logic [7:0]                 cal_count;
    logic [18:0]                phase_sum [3];
    logic [mds_pkg::OFF_W-1:0]  phase_offset [3];
    logic                       cal_fault_held;
    logic                       run_seen;

    function automatic void reset_supervisor_model();
        settings.init_ticks       = mds_pkg::INIT_TICKS_RST;
        settings.stop_ticks       = mds_pkg::STOP_TICKS_RST;
        settings.preopen_ticks    = mds_pkg::PREOPEN_TICKS_RST;
        settings.offset_nominal   = mds_pkg::OFFSET_NOM_RST;
        settings.offset_tolerance = mds_pkg::OFFSET_TOL_RST;
        sup_mode       = mds_pkg::MODE_INIT;
        sup_tick       = '0;
        cal_count      = '0;
        cal_fault_held = 1'b0;
        run_seen       = 1'b0;
        for (int i = 0; i < 3; i++) begin
            phase_sum[i]    = '0;
            phase_offset[i] = '0;
        end
    endfunction

    // Any state change restarts the tick timer.
    function automatic void enter_mode(input logic [2:0] next_mode);
        sup_mode = next_mode;
        sup_tick = '0;
    endfunction

    function automatic void bump_tick();
        if (sup_tick != mds_pkg::TICK_MAX)
            sup_tick = sup_tick + 1'b1;
    endfunction

    // One calibration step. Samples are summed for the first CAL_WINDOW
    // ticks, the averages are latched and checked on the next one, and the
    // pass reports done (and restarts) on the tick after that. The window
    // check is signed, so a window that reaches below zero or above full
    // scale behaves as an open side.
    function automatic logic calibration_step(input mds_pkg::in_word_t word);
        logic [mds_pkg::ADC_W-1:0] sample [3];
        int                        dev;
        sample[0] = word.adc_u;
        sample[1] = word.adc_v;
        sample[2] = word.adc_w;
        cal_count = cal_count + 1'b1;
        if (cal_count <= CAL_WINDOW) begin
            for (int i = 0; i < 3; i++)
                phase_sum[i] = phase_sum[i] + sample[i];
        end else if (cal_count == CAL_WINDOW + 1) begin
            for (int i = 0; i < 3; i++) begin
                phase_offset[i] = 12'(phase_sum[i] / CAL_WINDOW);
                dev = int'(phase_offset[i]) - int'(settings.offset_nominal);
                if (dev > int'(settings.offset_tolerance) ||
                    dev < -int'(settings.offset_tolerance))
                    cal_fault_held = 1'b1;
            end
        end else begin
            for (int i = 0; i < 3; i++)
                phase_sum[i] = '0;
            cal_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic mds_pkg::result_t advance_supervisor(input mds_pkg::in_word_t word);
        mds_pkg::result_t status;
        logic             cal_done;
        status = '0;

        // A host clear acts first, so the fault check below already sees it.
        if (word.fault_clear)
            cal_fault_held = 1'b0;
        // Outside init any active fault forces alarm before the state logic.
        if (sup_mode != mds_pkg::MODE_INIT && (word.external_fault || cal_fault_held))
            enter_mode(mds_pkg::MODE_ALARM);

        case (sup_mode)
            mds_pkg::MODE_INIT: begin
                run_seen = 1'b0;
                bump_tick();
                status.trip_reset = (sup_tick <= mds_pkg::TRIP_RESET_TICKS);
                cal_done = calibration_step(word);
                if (cal_done && sup_tick >= settings.init_ticks)
                    enter_mode(mds_pkg::MODE_STOP);
            end
            mds_pkg::MODE_STOP: begin
                run_seen = 1'b0;
                bump_tick();
                if (word.start_request && sup_tick >= settings.stop_ticks)
                    enter_mode(mds_pkg::MODE_PREOPEN);
            end
            mds_pkg::MODE_PREOPEN: begin
                bump_tick();
                status.pwm_enable = 1'b1;
                if (sup_tick < settings.preopen_ticks)
                    status.preopen_active = 1'b1;
                else
                    status.estimator_reset = 1'b1;
                if (sup_tick > settings.preopen_ticks) begin
                    enter_mode(mds_pkg::MODE_RUN);
                    run_seen = 1'b1;
                end
                // A dropped request wins over entering run in the same tick.
                if (!word.start_request) begin
                    enter_mode(mds_pkg::MODE_STOP);
                    run_seen = 1'b0;
                end
            end
            mds_pkg::MODE_RUN: begin
                status.pwm_enable = 1'b1;
                if (!word.start_request) begin
                    enter_mode(mds_pkg::MODE_STOP);
                    run_seen = 1'b0;
                end
            end
            default: begin
                // Alarm: ask the host to drop start, and return to init once
                // no fault is left. Entering init clears the latch.
                sup_mode = mds_pkg::MODE_ALARM;
                run_seen = 1'b0;
                status.clear_start = 1'b1;
                if (!(word.external_fault || cal_fault_held)) begin
                    enter_mode(mds_pkg::MODE_INIT);
                    cal_fault_held = 1'b0;
                end
            end
        endcase

        status.machine_state = sup_mode;
        status.run_indicator = run_seen;
        status.offset_u      = phase_offset[0];
        status.offset_v      = phase_offset[1];
        status.offset_w      = phase_offset[2];
        status.cal_fault     = cal_fault_held;
        return status;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------------
    mds_pkg::in_word_t pending_ticks [$];
    mds_pkg::result_t  predicted_status [$];
    int                ticks_planned = 0;
    int                ticks_checked = 0;
    int                mismatches = 0;
    int                hold_ticket = 0;

    // ------------------------------------------------------------------------
    // Driver. It offers planned words in bursts of random length separated by
    // random gaps; a gap of zero joins two bursts. A word that is offered
    // stays on the ports until the core takes it, and the model is advanced
    // at the edge where it is taken.
    // ------------------------------------------------------------------------
    mds_pkg::in_word_t offered;
    int                burst_left = 0;
    int                gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid       <= 1'b0;
            start_request  <= 1'b0;
            external_fault <= 1'b0;
            fault_clear    <= 1'b0;
            adc_u          <= '0;
            adc_v          <= '0;
            adc_w          <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_valid && in_ready)
                predicted_status.push_back(advance_supervisor(offered));

            if (in_valid && !in_ready) begin
                // Held: the same word stays on offer.
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                offered = pending_ticks.pop_front();
                in_valid       <= 1'b1;
                start_request  <= offered.start_request;
                external_fault <= offered.external_fault;
                fault_clear    <= offered.fault_clear;
                adc_u          <= offered.adc_u;
                adc_v          <= offered.adc_v;
                adc_w          <= offered.adc_w;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 48);
                burst_left--;
                if (burst_left == 0)
                    gap_left = $urandom_range(0, 7);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result word taken is checked against the oldest
    // prediction. The receiver switches between always ready, mostly ready
    // and mostly stalled for stretches of random length, and holds off
    // completely for a long stretch whenever the stimulus asks for it.
    // ------------------------------------------------------------------------
    mds_pkg::result_t want;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               rx_mode = 0;
    int               rx_left = 0;

    task automatic check_field(input string what, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t  %s: expected %0d, actual %0d", $time, what,
                         exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
            rx_left   = 0;
        end else begin
            if (out_valid && out_ready) begin
                ticks_checked++;
                if (predicted_status.size() == 0) begin
                    mismatches++;
                    $display("%0t  result word: expected none, actual state %0d",
                             $time, machine_state);
                end else begin
                    want = predicted_status.pop_front();
                    check_field("machine_state", want.machine_state, machine_state);
                    check_field("pwm_enable", want.pwm_enable, pwm_enable);
                    check_field("preopen_active", want.preopen_active, preopen_active);
                    check_field("run_indicator", want.run_indicator, run_indicator);
                    check_field("estimator_reset", want.estimator_reset, estimator_reset);
                    check_field("trip_reset", want.trip_reset, trip_reset);
                    check_field("offset_u", want.offset_u, offset_u);
                    check_field("offset_v", want.offset_v, offset_v);
                    check_field("offset_w", want.offset_w, offset_w);
                    check_field("cal_fault", want.cal_fault, cal_fault);
                    check_field("clear_start", want.clear_start, clear_start);
                end
            end

            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(8, 60);
                end
                rx_left--;
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run with no handshake on either channel for too long is
    // hung.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t  no handshake for %0d cycles", $time, HANG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus planning.
    // ------------------------------------------------------------------------
    logic plan_start_level = 1'b0;
    int   plan_hold_left = 0;

    function automatic logic [mds_pkg::ADC_W-1:0] clip_adc(input int value);
        if (value < 0)
            return '0;
        if (value > 4095)
            return '1;
        return 12'(value);
    endfunction

    function automatic mds_pkg::in_word_t tick_word(input logic st, input logic ex,
                                                    input logic cl, input int u,
                                                    input int v, input int w);
        mds_pkg::in_word_t word;
        word.start_request  = st;
        word.external_fault = ex;
        word.fault_clear    = cl;
        word.adc_u          = clip_adc(u);
        word.adc_v          = clip_adc(v);
        word.adc_w          = clip_adc(w);
        return word;
    endfunction

    function automatic void queue_tick(input mds_pkg::in_word_t word);
        pending_ticks.push_back(word);
        ticks_planned++;
    endfunction

    // Well-formed operation: the start request is held high and low for
    // stretches, so the machine walks stop, preopen and run; external faults
    // and host clears are occasional; the ADC samples sit around a chosen
    // level, with an occasional outlier from anywhere in the full range to pull the average off.
    function automatic void plan_ticks(input int count, input int center,
                                       input int spread, input int outlier_div);
        int                smp [3];
        mds_pkg::in_word_t word;
        for (int n = 0; n < count; n++) begin
            if (plan_hold_left == 0) begin
                plan_start_level = !plan_start_level;
                plan_hold_left = plan_start_level ? $urandom_range(5, 80)
                                                  : $urandom_range(1, 12);
            end
            plan_hold_left--;
            for (int i = 0; i < 3; i++) begin
                if (outlier_div != 0 && $urandom_range(0, outlier_div - 1) == 0)
                    smp[i] = $urandom_range(0, 4095);
                else
                    smp[i] = center + int'($urandom_range(0, 2 * spread)) - spread;
            end
            word = tick_word(plan_start_level, $urandom_range(0, 59) == 0,
                             $urandom_range(0, 9) == 0, smp[0], smp[1], smp[2]);
            queue_tick(word);
        end
    endfunction

    // Noise: every field random on every tick.
    function automatic void plan_noise(input int count);
        for (int n = 0; n < count; n++)
            queue_tick(tick_word($urandom_range(0, 1), $urandom_range(0, 1),
                                 $urandom_range(0, 1), $urandom_range(0, 4095),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095)));
    endfunction

    // Register writes go out only while no word is in flight, so the model
    // copy can be updated at once.
    task automatic write_reg(input logic [mds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mds_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mds_pkg::CFG_INIT_TICKS:    settings.init_ticks    = value;
            mds_pkg::CFG_STOP_TICKS:    settings.stop_ticks    = value;
            mds_pkg::CFG_PREOPEN_TICKS: settings.preopen_ticks = value;
            mds_pkg::CFG_OFFSET_NOM:
                settings.offset_nominal = value[mds_pkg::OFF_W-1:0];
            mds_pkg::CFG_OFFSET_TOL:
                settings.offset_tolerance = value[mds_pkg::OFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int init_t, input int stop_t,
                                  input int pre_t, input int nominal,
                                  input int tolerance);
        write_reg(mds_pkg::CFG_INIT_TICKS, 16'(init_t));
        write_reg(mds_pkg::CFG_STOP_TICKS, 16'(stop_t));
        write_reg(mds_pkg::CFG_PREOPEN_TICKS, 16'(pre_t));
        write_reg(mds_pkg::CFG_OFFSET_NOM, 16'(nominal));
        write_reg(mds_pkg::CFG_OFFSET_TOL, 16'(tolerance));
    endtask

    // Every planned word yields exactly one result, so once all results are
    // back the core is idle.
    task automatic wait_for_results();
        while (ticks_checked < ticks_planned)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int nominal;
        int tolerance;

        reset_supervisor_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset settings. These land in the first
        // twenty init ticks, where the trip reset is held, and take the
        // fields to their extremes and through alternating bit patterns.
        queue_tick(tick_word(1'b0, 1'b0, 1'b0, 0, 0, 0));
        queue_tick(tick_word(1'b1, 1'b1, 1'b1, 4095, 4095, 4095));
        queue_tick(tick_word(1'b1, 1'b0, 1'b0, 'hAAA, 'h555, 'hAAA));
        queue_tick(tick_word(1'b0, 1'b1, 1'b0, 'h555, 'hAAA, 'h555));
        queue_tick(tick_word(1'b0, 1'b0, 1'b1, 0, 4095, 0));
        queue_tick(tick_word(1'b1, 1'b1, 1'b0, 4095, 0, 4095));
        repeat (14)
            queue_tick(tick_word($urandom_range(0, 1), $urandom_range(0, 1),
                                 $urandom_range(0, 1), 2048, 2000, 2100));
        // Finish the first calibration and move on into stop.
        plan_ticks(230, 2048, 80, 0);
        wait_for_results();

        // Zero delays everywhere and a window as wide as it goes.
        apply_settings(0, 0, 0, 2048, 4095);
        plan_ticks(120, 2048, 2047, 4);
        wait_for_results();

        // Short delays and a window that reaches below zero.
        apply_settings(3, 2, 6, 50, 120);
        plan_ticks(120, 40, 60, 16);
        wait_for_results();

        // Closed window at zero: only an exact zero average passes.
        apply_settings(0, 0, 1, 0, 0);
        plan_ticks(100, 0, 0, 0);
        wait_for_results();

        // Window at full scale that reaches above it.
        apply_settings(10, 5, 20, 4095, 3);
        plan_ticks(120, 4095, 5, 32);
        wait_for_results();

        // Random settings, with the samples sometimes off the window.
        repeat (2) begin
            nominal   = $urandom_range(0, 4095);
            tolerance = $urandom_range(0, 150);
            apply_settings($urandom_range(0, 40), $urandom_range(0, 30),
                           $urandom_range(0, 40), nominal, tolerance);
            plan_ticks(80, nominal + int'($urandom_range(0, 300)) - 150,
                       $urandom_range(0, 80), 16);
            wait_for_results();
        end

        // Back the core up: the receiver holds off while words keep coming.
        apply_settings(0, 0, 4, 2048, 200);
        hold_ticket++;
        plan_ticks(150, 2048, 100, 8);
        wait_for_results();

        // Preopen that never elapses, then pure noise.
        apply_settings(0, 0, 65534, 2048, 300);
        plan_ticks(80, 2048, 100, 0);
        plan_noise(40);
        wait_for_results();

        // Init and stop delays just below the register maximum. A fault followed by a clear brings
        // the machine back to init, where it then stays.
        apply_settings(65534, 65534, 0, 2048, 100);
        queue_tick(tick_word(1'b0, 1'b1, 1'b0, 2048, 2048, 2048));
        queue_tick(tick_word(1'b0, 1'b0, 1'b1, 2048, 2048, 2048));
        plan_ticks(40, 2048, 60, 0);
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_status.size() != 0) begin
            mismatches++;
            $display("%0t  result words: expected %0d more, actual 0", $time,
                     predicted_status.size());
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/mds_pkg.sv
src/mds_cfg_regs.sv
src/mds_cal_unit.sv
src/mds_seq.sv
src/motor_drive_supervisor_core.sv
src/mds_checker.sv
tb/motor_drive_supervisor_core_test.sv
